// ----- design/rse_pkg.sv -----
// Shared types, constants and the control store for the Rossler Euler stepper.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rse_pkg;

   // Fixed widths of the fixed-point datapath.
   localparam int WORD_W = 32;
   localparam int OPND_W = 33;
   localparam int PROD_W = 66;
   localparam int WIDE_W = 68;
   localparam int SQ_W   = 64;
   localparam int ROOT_W = 32;
   localparam int DT_W   = 17;
   localparam int PC_W   = 4;

   // Program addresses that the sequencer enters or jumps to.
   localparam logic [PC_W-1:0] PC_RESTART  = 4'd0;
   localparam logic [PC_W-1:0] PC_STEP     = 4'd2;
   localparam logic [PC_W-1:0] PC_SQ_FIRST = 4'd9;

   typedef enum logic [2:0] {
      CSR_COEF_A    = 3'd0,
      CSR_COEF_B    = 3'd1,
      CSR_COEF_C    = 3'd2,
      CSR_TIME_STEP = 3'd3,
      CSR_INIT_X    = 3'd4,
      CSR_INIT_Y    = 3'd5,
      CSR_INIT_Z    = 3'd6
   } rse_csr_index_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_AY,
      MUL_XZ,
      MUL_CZ,
      MUL_DTEX,
      MUL_DTEY,
      MUL_DTEZ,
      MUL_DXDX,
      MUL_DYDY,
      MUL_DZDZ,
      MUL_XY,
      MUL_YZ
   } rse_mul_op_type;

   typedef enum logic [3:0] {
      ALU_NONE,
      ALU_INIT,
      ALU_DX,
      ALU_DY,
      ALU_ACC,
      ALU_DZ,
      ALU_POSX,
      ALU_POSY,
      ALU_POSZ,
      ALU_SQLOAD,
      ALU_SQADD,
      ALU_PXY,
      ALU_PXZ,
      ALU_PYZ
   } rse_alu_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_GOTO,
      SEQ_OUT
   } rse_seq_op_type;

   typedef struct packed {
      rse_mul_op_type  mul;
      rse_alu_op_type  alu;
      rse_seq_op_type  seq;
      logic [PC_W-1:0] target;
      logic            sqrt_start;
   } rse_uword_type;

   typedef struct packed {
      logic                     func;
      logic signed [WORD_W-1:0] drive_x;
      logic signed [WORD_W-1:0] drive_y;
      logic signed [WORD_W-1:0] drive_z;
   } rse_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_z;
      logic signed [WORD_W-1:0] vel_x;
      logic signed [WORD_W-1:0] vel_y;
      logic signed [WORD_W-1:0] vel_z;
      logic [WORD_W-2:0]        speed;
      logic signed [WORD_W-1:0] prod_xy;
      logic signed [WORD_W-1:0] prod_xz;
      logic signed [WORD_W-1:0] prod_yz;
   } rse_rsp_type;

   // Request to and status from the square root unit.
   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] operand;
   } rse_sqrt_req_type;

   typedef struct packed {
      logic              busy;
      logic [ROOT_W-1:0] root;
   } rse_sqrt_stat_type;

   // Sign-extend a state word to the wide accumulation width.
   function automatic logic signed [WIDE_W-1:0] ext_wide(input logic signed [WORD_W-1:0] v);
      ext_wide = {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

   // Clamp a wide signed value into the signed word range.
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-WORD_W:0] upper;
      upper = v[WIDE_W-1:WORD_W-1];
      if ((&upper) || !(|upper)) begin
         sat_word = v[WORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         sat_word = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         sat_word = {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

   // Control store. A word may start a multiply and retire the product
   // of the word before it; words 0, 14 and 15 start no multiply.
   function automatic rse_uword_type rse_ucode(input logic [PC_W-1:0] pc);
      rse_uword_type w;
      w = '{mul: MUL_NONE, alu: ALU_NONE, seq: SEQ_NEXT, target: PC_RESTART,
            sqrt_start: 1'b0};
      case (pc)
         4'd0: begin
            w.alu = ALU_INIT;
         end
         4'd1: begin
            w.mul    = MUL_DXDX;
            w.seq    = SEQ_GOTO;
            w.target = PC_SQ_FIRST;
         end
         4'd2: begin
            w.mul = MUL_AY;
            w.alu = ALU_DX;
         end
         4'd3: begin
            w.mul = MUL_XZ;
            w.alu = ALU_DY;
         end
         4'd4: begin
            w.mul = MUL_CZ;
            w.alu = ALU_ACC;
         end
         4'd5: begin
            w.mul = MUL_DTEX;
            w.alu = ALU_DZ;
         end
         4'd6: begin
            w.mul = MUL_DTEY;
            w.alu = ALU_POSX;
         end
         4'd7: begin
            w.mul = MUL_DTEZ;
            w.alu = ALU_POSY;
         end
         4'd8: begin
            w.mul = MUL_DXDX;
            w.alu = ALU_POSZ;
         end
         4'd9: begin
            w.mul = MUL_DYDY;
            w.alu = ALU_SQLOAD;
         end
         4'd10: begin
            w.mul = MUL_DZDZ;
            w.alu = ALU_SQADD;
         end
         4'd11: begin
            w.mul = MUL_XY;
            w.alu = ALU_SQADD;
         end
         4'd12: begin
            w.mul        = MUL_XZ;
            w.alu        = ALU_PXY;
            w.sqrt_start = 1'b1;
         end
         4'd13: begin
            w.mul = MUL_YZ;
            w.alu = ALU_PXZ;
         end
         4'd14: begin
            w.alu = ALU_PYZ;
         end
         4'd15: begin
            w.seq = SEQ_OUT;
         end
         default: begin
            w.seq = SEQ_OUT;
         end
      endcase
      rse_ucode = w;
   endfunction

endpackage

`default_nettype wire

// ----- design/rse_isqrt.sv -----
// Integer square root of a 64-bit value, two result bits per cycle.
// Depends on rse_pkg for the widths and the request and status structs.
`default_nettype none

module rse_isqrt (
   input  wire                       clock,
   input  wire                       reset,
   input  rse_pkg::rse_sqrt_req_type sqrt_req,
   output rse_pkg::rse_sqrt_stat_type sqrt_stat
);
   import rse_pkg::*;

   localparam int REM_W   = ROOT_W + 4;
   localparam int ITERS   = SQ_W / 4;
   localparam int CNT_W   = $clog2(ITERS);

   logic [SQ_W-1:0]   n_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;

   // Two restoring digit steps: bring down a bit pair, try the trial divisor.
   always_comb begin
      logic [REM_W-1:0]  r;
      logic [REM_W-1:0]  t;
      logic [ROOT_W-1:0] q;
      r = rem_ff;
      q = root_ff;
      for (int k = 0; k < 2; k++) begin
         r = {r[REM_W-3:0], n_ff[SQ_W-1-2*k -: 2]};
         t = {2'b00, q, 2'b01};
         if (r >= t) begin
            r = r - t;
            q = {q[ROOT_W-2:0], 1'b1};
         end else begin
            q = {q[ROOT_W-2:0], 1'b0};
         end
      end
      rem_in  = r;
      root_in = q;
   end

   // Control: a start loads the operand, the count runs out after all pairs.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (sqrt_req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(ITERS - 1);
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != '0);
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   // Operand shift and partial root.
   always_ff @(posedge clock) begin
      if (sqrt_req.start) begin
         n_ff    <= sqrt_req.operand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         n_ff    <= {n_ff[SQ_W-5:0], 4'b0000};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign sqrt_stat.busy = busy_ff;
   assign sqrt_stat.root = root_ff;

endmodule

`default_nettype wire

// ----- design/rossler_euler_step.sv -----
// Rossler system, one forward-Euler step per item, in signed fixed point.
// A new item is taken the cycle after the result of the last one is loaded; a result
// loads once the square root is done and the output register is free or transferring.
// The 64-bit square root, two bits a cycle, runs beside the output products; the multiplier is shared.
// Synchronous active-high reset restores the register defaults and the start point.
// Depends on rse_pkg and rse_isqrt.
`default_nettype none

module rossler_euler_step #(
   parameter int FRAC_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  rse_pkg::rse_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output rse_pkg::rse_rsp_type rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [2:0]           csr_index,
   input  wire  [31:0]          csr_data
);
   import rse_pkg::*;

   localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

   // Configuration registers.
   logic signed [WORD_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic signed [WORD_W-1:0] init_x_ff, init_y_ff, init_z_ff;
   logic [DT_W-1:0]          time_step_ff;

   // Sequencer.
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff;
   logic            accept;
   logic            out_load;
   rse_uword_type   ctl;
   rse_mul_op_type  mul_op;
   rse_alu_op_type  alu_op;

   // Datapath.
   rse_req_type              drv_ff;
   logic signed [WORD_W-1:0] x_ff, y_ff, z_ff, dx_ff, dy_ff, dz_ff;
   logic signed [WORD_W-1:0] pxy_ff, pxz_ff, pyz_ff;
   logic signed [OPND_W-1:0] ex_ff, ey_ff, ez_ff;
   logic signed [WIDE_W-1:0] acc_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SQ_W-1:0]          sq_ff;
   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic signed [WIDE_W-1:0] prod_ext, rnd;
   logic signed [WORD_W-1:0] dx_in, dy_in, dz_in;

   // Output register.
   rse_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   rse_sqrt_req_type  sqrt_req;
   rse_sqrt_stat_type sqrt_stat;

   assign csr_ready = 1'b1;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff    <= 32'sd13107;
         coef_b_ff    <= 32'sd13107;
         coef_c_ff    <= 32'sd373555;
         time_step_ff <= 17'd655;
         init_x_ff    <= 32'sd65536;
         init_y_ff    <= '0;
         init_z_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COEF_A:    coef_a_ff    <= csr_data;
            CSR_COEF_B:    coef_b_ff    <= csr_data;
            CSR_COEF_C:    coef_c_ff    <= csr_data;
            CSR_TIME_STEP: time_step_ff <= csr_data[DT_W-1:0];
            CSR_INIT_X:    init_x_ff    <= csr_data;
            CSR_INIT_Y:    init_y_ff    <= csr_data;
            CSR_INIT_Z:    init_z_ff    <= csr_data;
            default:       ;
         endcase
      end
   end

   // Sequencer: the current control word, gated while idle.
   assign req_stall = busy_ff;
   assign accept    = req_valid && !req_stall;
   assign ctl       = rse_ucode(pc_ff);
   assign mul_op    = busy_ff ? ctl.mul : MUL_NONE;
   assign alu_op    = busy_ff ? ctl.alu : ALU_NONE;
   assign out_load  = busy_ff && (ctl.seq == SEQ_OUT) && !sqrt_stat.busy &&
                      (!rsp_valid_ff || !rsp_stall);

   // Next program address.
   always_comb begin
      pc_in = pc_ff;
      if (accept) begin
         pc_in = req_data.func ? PC_RESTART : PC_STEP;
      end else if (busy_ff) begin
         case (ctl.seq)
            SEQ_NEXT: pc_in = pc_ff + 1'b1;
            SEQ_GOTO: pc_in = ctl.target;
            SEQ_OUT:  pc_in = pc_ff;
            default:  pc_in = pc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_RESTART;
      end else begin
         pc_ff <= pc_in;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (out_load) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Drives are held for the whole item.
   always_ff @(posedge clock) begin
      if (accept) begin
         drv_ff <= req_data;
      end
   end

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (mul_op)
         MUL_AY:   begin mul_a = {coef_a_ff[WORD_W-1], coef_a_ff}; mul_b = {y_ff[WORD_W-1], y_ff}; end
         MUL_XZ:   begin mul_a = {x_ff[WORD_W-1], x_ff};   mul_b = {z_ff[WORD_W-1], z_ff}; end
         MUL_CZ:   begin mul_a = {coef_c_ff[WORD_W-1], coef_c_ff}; mul_b = {z_ff[WORD_W-1], z_ff}; end
         MUL_DTEX: begin mul_a = {{(OPND_W-DT_W){1'b0}}, time_step_ff}; mul_b = ex_ff; end
         MUL_DTEY: begin mul_a = {{(OPND_W-DT_W){1'b0}}, time_step_ff}; mul_b = ey_ff; end
         MUL_DTEZ: begin mul_a = {{(OPND_W-DT_W){1'b0}}, time_step_ff}; mul_b = ez_ff; end
         MUL_DXDX: begin mul_a = {dx_ff[WORD_W-1], dx_ff}; mul_b = {dx_ff[WORD_W-1], dx_ff}; end
         MUL_DYDY: begin mul_a = {dy_ff[WORD_W-1], dy_ff}; mul_b = {dy_ff[WORD_W-1], dy_ff}; end
         MUL_DZDZ: begin mul_a = {dz_ff[WORD_W-1], dz_ff}; mul_b = {dz_ff[WORD_W-1], dz_ff}; end
         MUL_XY:   begin mul_a = {x_ff[WORD_W-1], x_ff};   mul_b = {y_ff[WORD_W-1], y_ff}; end
         MUL_YZ:   begin mul_a = {y_ff[WORD_W-1], y_ff};   mul_b = {z_ff[WORD_W-1], z_ff}; end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // The shared multiplier; its product is retired by the next control word.
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (mul_op != MUL_NONE) begin
         prod_ff <= prod_in;
      end
   end

   // Rescale the held product, rounding half toward positive infinity.
   assign prod_ext = {{(WIDE_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign rnd      = (prod_ext + HALF) >>> FRAC_BITS;

   // Derivative values as they are written back.
   assign dx_in = sat_word(-ext_wide(y_ff) - ext_wide(z_ff));
   assign dy_in = sat_word(ext_wide(x_ff) + rnd);
   assign dz_in = sat_word(acc_ff - rnd);

   // State and derivative write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff  <= 32'sd65536;
         y_ff  <= '0;
         z_ff  <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
         dz_ff <= '0;
      end else begin
         case (alu_op)
            ALU_INIT: begin
               x_ff  <= init_x_ff;
               y_ff  <= init_y_ff;
               z_ff  <= init_z_ff;
               dx_ff <= '0;
               dy_ff <= '0;
               dz_ff <= '0;
            end
            ALU_DX:   dx_ff <= dx_in;
            ALU_DY:   dy_ff <= dy_in;
            ALU_DZ:   dz_ff <= dz_in;
            ALU_POSX: x_ff  <= sat_word(ext_wide(x_ff) + rnd);
            ALU_POSY: y_ff  <= sat_word(ext_wide(y_ff) + rnd);
            ALU_POSZ: z_ff  <= sat_word(ext_wide(z_ff) + rnd);
            default:  ;
         endcase
      end
   end

   // Intermediate sums, squares and output products.
   always_ff @(posedge clock) begin
      case (alu_op)
         ALU_DX:     ex_ff  <= {dx_in[WORD_W-1], dx_in} +
                               {drv_ff.drive_x[WORD_W-1], drv_ff.drive_x};
         ALU_DY:     ey_ff  <= {dy_in[WORD_W-1], dy_in} +
                               {drv_ff.drive_y[WORD_W-1], drv_ff.drive_y};
         ALU_DZ:     ez_ff  <= {dz_in[WORD_W-1], dz_in} +
                               {drv_ff.drive_z[WORD_W-1], drv_ff.drive_z};
         ALU_ACC:    acc_ff <= ext_wide(coef_b_ff) + rnd;
         ALU_SQLOAD: sq_ff  <= prod_ff[SQ_W-1:0];
         ALU_SQADD:  sq_ff  <= sq_ff + prod_ff[SQ_W-1:0];
         ALU_PXY:    pxy_ff <= sat_word(rnd);
         ALU_PXZ:    pxz_ff <= sat_word(rnd);
         ALU_PYZ:    pyz_ff <= sat_word(rnd);
         default:    ;
      endcase
   end

   // Square root of the sum of squares runs beside the output products.
   assign sqrt_req.start   = busy_ff && ctl.sqrt_start;
   assign sqrt_req.operand = sq_ff;

   rse_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .sqrt_req  (sqrt_req),
      .sqrt_stat (sqrt_stat)
   );

   // Output register; a new result may load as the old one transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.pos_x   <= x_ff;
         rsp_ff.pos_y   <= y_ff;
         rsp_ff.pos_z   <= z_ff;
         rsp_ff.vel_x   <= dx_ff;
         rsp_ff.vel_y   <= dy_ff;
         rsp_ff.vel_z   <= dz_ff;
         rsp_ff.speed   <= sqrt_stat.root[ROOT_W-1] ? {(WORD_W-1){1'b1}}
                                                    : sqrt_stat.root[WORD_W-2:0];
         rsp_ff.prod_xy <= pxy_ff;
         rsp_ff.prod_xz <= pxz_ff;
         rsp_ff.prod_yz <= pyz_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result load ends the item and leaves a result waiting.
   a_load_ends_item: assert property (@(posedge clock) disable iff (reset)
      out_load |=> !busy_ff && rsp_valid_ff)
      else $error("result load did not end the item");

   // The root unit is never restarted while it is still working.
   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sqrt_req.start |-> !sqrt_stat.busy)
      else $error("square root started while busy");

   // A restart item enters the program at the restart entry.
   a_restart_entry: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.func |=> busy_ff && (pc_ff == PC_RESTART))
      else $error("restart item did not enter the restart program");

   // An item stays in flight until its result is loaded.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !out_load |=> busy_ff)
      else $error("item ended without a result load");

endmodule

`default_nettype wire

// ----- bench/tb_rossler_euler_step.sv -----
// Testbench for rossler_euler_step: directed and random Euler steps and restarts,
// each result predicted in fixed point and compared field by field.
// Depends on rse_pkg and the rossler_euler_step RTL only.

module tb_rossler_euler_step;
   import rse_pkg::*;

   localparam int FRAC = 16;
   localparam longint WORD_MAX = 64'sh7fff_ffff;
   localparam longint WORD_MIN = -64'sh8000_0000;
   localparam logic [31:0] MAX32 = 32'h7fff_ffff;
   localparam logic [31:0] MIN32 = 32'h8000_0000;
   localparam logic [31:0] ONE_Q = 32'h0001_0000;
   localparam logic [16:0] STEP_ONE = 17'h1_0000;
   localparam logic [16:0] STEP_TOP = 17'h1_ffff;

   // Register defaults after reset.
   localparam logic [31:0] RST_COEF_AB = 32'd13107;
   localparam logic [31:0] RST_COEF_C = 32'd373555;
   localparam logic [16:0] RST_STEP = 17'd655;

   // Item kinds carried in the func field.
   localparam logic FUNC_STEP = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 86;
   localparam int PRESSURE_PHASE = 3;
   localparam int PAUSE_PHASE = 5;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rse_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rse_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   rse_csr_index_type csr_index = CSR_COEF_A;
   logic [31:0] csr_data = '0;

   // Items waiting for the driver, and results predicted but not yet seen.
   rse_req_type drive_queue[$];
   rse_rsp_type predicted_points[$];

   // Predictor copy of the registers and the integrator state.
   logic signed [31:0] cfg_a, cfg_b, cfg_c, cfg_x0, cfg_y0, cfg_z0;
   logic [16:0] cfg_dt;
   logic signed [31:0] st_x, st_y, st_z, dv_x, dv_y, dv_z;

   logic sender_idle = 1'b0;
   logic receiver_idle = 1'b0;
   int req_gap = 0;
   int hold_req = 0;
   int hold_ack = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;

   // Items queued so far and results that have come back.
   int items_added = 0;
   int results_seen = 0;

   rossler_euler_step #(.FRAC_BITS(FRAC)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Fixed-point product, rounded half up.
   function automatic longint fx_mul(longint p, longint q);
      longint prod;
      prod = p * q;
      return (prod + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic logic signed [31:0] clamp_word(longint v);
      if (v > WORD_MAX) return 32'sh7fff_ffff;
      if (v < WORD_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Integer square root of the sum of squares, built one result bit at a time.
   function automatic logic [30:0] norm3(logic signed [31:0] a, logic signed [31:0] b,
                                         logic signed [31:0] c);
      logic [63:0] sum, root, trial;
      sum = 64'(longint'(a) * longint'(a));
      sum = sum + 64'(longint'(b) * longint'(b));
      sum = sum + 64'(longint'(c) * longint'(c));
      root = '0;
      for (int k = 31; k >= 0; k--) begin
         trial = root | (64'd1 << k);
         if (trial * trial <= sum) root = trial;
      end
      return (root > 64'h7fff_ffff) ? 31'h7fff_ffff : root[30:0];
   endfunction

   // Advance the predicted system by one item and return the expected result.
   function automatic rse_rsp_type euler_advance(rse_req_type item);
      rse_rsp_type r;
      longint x, y, z, dt;
      if (item.func == FUNC_RESTART) begin
         st_x = cfg_x0;
         st_y = cfg_y0;
         st_z = cfg_z0;
         dv_x = '0;
         dv_y = '0;
         dv_z = '0;
      end else begin
         x = st_x;
         y = st_y;
         z = st_z;
         dt = longint'({47'd0, cfg_dt});
         dv_x = clamp_word(-y - z);
         dv_y = clamp_word(x + fx_mul(cfg_a, y));
         dv_z = clamp_word(longint'(cfg_b) + fx_mul(x, z) - fx_mul(cfg_c, z));
         st_x = clamp_word(x + fx_mul(dt, longint'(dv_x) + longint'(item.drive_x)));
         st_y = clamp_word(y + fx_mul(dt, longint'(dv_y) + longint'(item.drive_y)));
         st_z = clamp_word(z + fx_mul(dt, longint'(dv_z) + longint'(item.drive_z)));
      end
      r.pos_x = st_x;
      r.pos_y = st_y;
      r.pos_z = st_z;
      r.vel_x = dv_x;
      r.vel_y = dv_y;
      r.vel_z = dv_z;
      r.speed = norm3(dv_x, dv_y, dv_z);
      r.prod_xy = clamp_word(fx_mul(st_x, st_y));
      r.prod_xz = clamp_word(fx_mul(st_x, st_z));
      r.prod_yz = clamp_word(fx_mul(st_y, st_z));
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 50);
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 4))
         0: return MAX32;
         1: return MIN32;
         2: return '0;
         3: return ONE_Q;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   function automatic void add_item(logic func, logic [31:0] dx, logic [31:0] dy,
                                    logic [31:0] dz);
      rse_req_type item;
      item.func = func;
      item.drive_x = dx;
      item.drive_y = dy;
      item.drive_z = dz;
      drive_queue.push_back(item);
      items_added++;
   endfunction

   // Mostly steps with small drives; some restarts, idle steps and full-range noise.
   function automatic void add_random_item();
      logic signed [31:0] d [3];
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         add_item(FUNC_RESTART, $urandom(), $urandom(), $urandom());
      end else if (r < 14) begin
         add_item(FUNC_STEP, $urandom(), $urandom(), $urandom());
      end else if (r < 35) begin
         add_item(FUNC_STEP, '0, '0, '0);
      end else begin
         for (int i = 0; i < 3; i++) begin
            d[i] = $urandom();
            d[i] = d[i] >>> $urandom_range(10, 31);
         end
         add_item(FUNC_STEP, d[0], d[1], d[2]);
      end
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", field, want, got);
         mismatches++;
      end
   endtask

   // One register transfer; the caller lowers csr_valid after the last one.
   task automatic write_reg(rse_csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [16:0] dt, logic [31:0] x0, logic [31:0] y0,
                              logic [31:0] z0);
      write_reg(CSR_COEF_A, a);
      write_reg(CSR_COEF_B, b);
      write_reg(CSR_COEF_C, c);
      write_reg(CSR_TIME_STEP, {15'd0, dt});
      write_reg(CSR_INIT_X, x0);
      write_reg(CSR_INIT_Y, y0);
      write_reg(CSR_INIT_Z, z0);
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued item has come back as a result.
   task automatic drain();
      do @(posedge clock);
      while (results_seen < items_added);
   endtask

   // Request driver; it also tracks register writes and predicts each accepted item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
         cfg_a = RST_COEF_AB;
         cfg_b = RST_COEF_AB;
         cfg_c = RST_COEF_C;
         cfg_dt = RST_STEP;
         cfg_x0 = ONE_Q;
         cfg_y0 = '0;
         cfg_z0 = '0;
         st_x = ONE_Q;
         st_y = '0;
         st_z = '0;
         dv_x = '0;
         dv_y = '0;
         dv_z = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COEF_A: cfg_a = csr_data;
               CSR_COEF_B: cfg_b = csr_data;
               CSR_COEF_C: cfg_c = csr_data;
               CSR_TIME_STEP: cfg_dt = csr_data[16:0];
               CSR_INIT_X: cfg_x0 = csr_data;
               CSR_INIT_Y: cfg_y0 = csr_data;
               CSR_INIT_Z: cfg_z0 = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted_points.push_back(euler_advance(req_data));
         end
         // A stalled item stays on the port; otherwise idle or offer the next one.
         if (req_valid && req_stall) begin
         end else if (req_gap != 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (drive_queue.size() != 0) begin
            req_data <= drive_queue.pop_front();
            req_valid <= 1'b1;
            req_gap <= sender_idle ? idle_len() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and receiver stall pattern.
   always @(posedge clock) begin
      rse_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_points.size() == 0) begin
               $error("result transfer with no prediction waiting");
               mismatches++;
            end else begin
               want = predicted_points.pop_front();
               check_field("pos_x", want.pos_x, rsp_data.pos_x);
               check_field("pos_y", want.pos_y, rsp_data.pos_y);
               check_field("pos_z", want.pos_z, rsp_data.pos_z);
               check_field("vel_x", want.vel_x, rsp_data.vel_x);
               check_field("vel_y", want.vel_y, rsp_data.vel_y);
               check_field("vel_z", want.vel_z, rsp_data.vel_z);
               check_field("speed", {1'b0, want.speed}, {1'b0, rsp_data.speed});
               check_field("prod_xy", want.prod_xy, rsp_data.prod_xy);
               check_field("prod_xz", want.prod_xz, rsp_data.prod_xz);
               check_field("prod_yz", want.prod_yz, rsp_data.prod_yz);
            end
         end
         // A long hold-off on request, else random short and long stalls.
         if (hold_ack != hold_req) begin
            hold_ack <= hold_req;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
            hold_left <= idle_len();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus sequence: directed corners first, then randomized phases.
   initial begin
      logic [31:0] pa, pb, pc, px, py, pz;
      logic [16:0] pdt;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      sender_idle <= 1'b1;
      receiver_idle <= 1'b1;

      // Register defaults, drive extremes, and a restart whose drives are ignored.
      add_item(FUNC_STEP, '0, '0, '0);
      add_item(FUNC_STEP, '0, '0, '0);
      add_item(FUNC_STEP, MAX32, MAX32, MAX32);
      add_item(FUNC_STEP, MIN32, MIN32, MIN32);
      add_item(FUNC_STEP, ONE_Q, 32'hffff_0000, 32'h0000_8000);
      add_item(FUNC_RESTART, MAX32, MIN32, MAX32);
      add_item(FUNC_STEP, '0, '0, '0);
      drain();

      // Extreme parameters with a time step above 1.0, pushing the datapath toward saturation.
      program_all(MAX32, MAX32, MIN32, STEP_TOP, MAX32, MAX32, MIN32);
      add_item(FUNC_RESTART, '0, '0, '0);
      add_item(FUNC_STEP, MAX32, MAX32, MAX32);
      add_item(FUNC_STEP, MIN32, MIN32, MIN32);
      add_item(FUNC_STEP, '0, '0, '0);
      drain();

      // Opposite extremes with a zero time step: the state must not move.
      program_all(MIN32, MIN32, MAX32, '0, MIN32, MIN32, MAX32);
      add_item(FUNC_RESTART, '0, '0, '0);
      add_item(FUNC_STEP, MAX32, MIN32, MAX32);
      add_item(FUNC_STEP, '0, '0, '0);
      drain();

      // Zero parameters at the origin with a step of exactly 1.0.
      program_all('0, '0, '0, STEP_ONE, '0, '0, '0);
      add_item(FUNC_RESTART, '0, '0, '0);
      add_item(FUNC_STEP, '0, '0, '0);
      add_item(FUNC_STEP, ONE_Q, 32'hffff_0000, 32'h1234_5678);
      drain();

      // Classic parameters from a point off the axes.
      program_all(RST_COEF_AB, RST_COEF_AB, RST_COEF_C, RST_STEP, ONE_Q, ONE_Q, ONE_Q);
      add_item(FUNC_RESTART, '0, '0, '0);
      add_item(FUNC_STEP, '0, '0, '0);
      add_item(FUNC_STEP, 32'h0000_0100, 32'hffff_ff00, '0);
      add_item(FUNC_STEP, '0, '0, '0);
      add_item(FUNC_STEP, '0, '0, 32'h0002_0000);
      add_item(FUNC_RESTART, '0, '0, '0);
      add_item(FUNC_STEP, '0, '0, '0);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         sender_idle <= (ph != 0) && (ph != PRESSURE_PHASE) && ($urandom_range(0, 3) != 0);
         receiver_idle <= (ph != 0) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               pa = 32'(RST_COEF_AB + $urandom_range(0, 16000) - 8000);
               pb = 32'(RST_COEF_AB + $urandom_range(0, 16000) - 8000);
               pc = 32'(RST_COEF_C + $urandom_range(0, 400000) - 200000);
               pdt = 17'($urandom_range(1, 4000));
            end
            6, 7: begin
               pa = $urandom();
               pb = $urandom();
               pc = $urandom();
               pdt = 17'($urandom_range(0, 131071));
            end
            8: begin
               pa = corner_word();
               pb = corner_word();
               pc = corner_word();
               case ($urandom_range(0, 2))
                  0: pdt = '0;
                  1: pdt = STEP_ONE;
                  default: pdt = STEP_TOP;
               endcase
            end
            default: begin
               pa = RST_COEF_AB;
               pb = RST_COEF_AB;
               pc = RST_COEF_C;
               pdt = 17'($urandom_range(32768, 131071));
            end
         endcase
         px = 32'($urandom_range(0, 20 << 16) - (10 << 16));
         py = 32'($urandom_range(0, 20 << 16) - (10 << 16));
         pz = 32'($urandom_range(0, 20 << 16) - (10 << 16));
         program_all(pa, pb, pc, pdt, px, py, pz);

         // Each phase starts from a clean restart, then runs its sequence.
         add_item(FUNC_RESTART, '0, '0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) drain();
            add_random_item();
         end
         // The receiver holds off while the sender keeps offering items.
         if (ph == PRESSURE_PHASE) hold_req <= hold_req + 1;
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_points.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rse_pkg.sv
design/rse_isqrt.sv
design/rossler_euler_step.sv
bench/tb_rossler_euler_step.sv
